/* hw/rtl/inode_bitmap_allocator_defines.svh */
// Assertion helpers for the inode bitmap allocator.
`ifndef INODE_BITMAP_ALLOCATOR_DEFINES_SVH
`define INODE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ibmp_pkg.sv */
package ibmp_pkg;

    localparam int WORD_W            = 32;
    localparam int CFG_W             = 9;
    localparam int ID_W              = 11;
    localparam int ADDR_W            = 3;
    localparam int PDATA_W           = 32;
    localparam int EPG_RESET         = 256;
    localparam int DEF_GROUPS        = 4;
    localparam int DEF_MAX_PER_GROUP = 256;

    // register index, taken from paddr[2]
    localparam logic REG_EPG = 1'b0;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FDIV,
        S_FCHK
    } t_state;

    // id decode unit result
    typedef struct packed {
        logic done;
        logic range_err;
    } t_div_res;

endpackage

/* hw/rtl/ibmp_cfg.sv */
module ibmp_cfg import ibmp_pkg::*; #(
    parameter int MAX_PER_GROUP = DEF_MAX_PER_GROUP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CFG_W-1:0]   o_epg
);

    logic [CFG_W-1:0] r_epg;
    logic             w_sel;

    assign w_sel  = (paddr[2] == REG_EPG);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epg <= CFG_W'(EPG_RESET);
        end else if (psel && penable && pwrite && w_sel) begin
            r_epg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = w_sel ? {{(PDATA_W-CFG_W){1'b0}}, r_epg} : '0;

    // saturate to the bits each group owns
    always_comb begin
        if (32'(r_epg) > MAX_PER_GROUP) begin
            o_epg = CFG_W'(MAX_PER_GROUP);
        end else begin
            o_epg = r_epg;
        end
    end

endmodule

/* hw/rtl/ibmp_mem.sv */
module ibmp_mem import ibmp_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/ibmp_idiv.sv */
module ibmp_idiv import ibmp_pkg::*; #(
    parameter int GROUPS        = DEF_GROUPS,
    parameter int MAX_PER_GROUP = DEF_MAX_PER_GROUP,
    parameter int PW            = 11,
    parameter int GW            = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ID_W-1:0]  i_entry_id,
    input  logic [CFG_W-1:0] i_epg,
    output t_div_res         o_res,
    output logic [PW-1:0]    o_pos
);

    // Group found by repeated subtraction of entries_per_group, one per cycle.
    logic             r_busy;
    t_div_res         r_res;
    logic [ID_W-1:0]  r_rem;
    logic [GW-1:0]    r_grp;
    logic [PW-1:0]    r_gbase;
    logic [PW-1:0]    r_pos;
    logic [ID_W-1:0]  w_epg;

    assign w_epg = ID_W'(i_epg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_res  <= '0;
        end else begin
            if (i_start) begin
                if (i_entry_id == '0 || i_epg == '0) begin
                    r_res <= '{done: 1'b1, range_err: 1'b1};
                end else begin
                    r_busy <= 1'b1;
                    r_res  <= '0;
                end
            end else if (r_busy) begin
                if (r_rem < w_epg) begin
                    r_busy <= 1'b0;
                    r_res  <= '{done: 1'b1, range_err: 1'b0};
                end else if (r_grp == GW'(GROUPS - 1)) begin
                    r_busy <= 1'b0;
                    r_res  <= '{done: 1'b1, range_err: 1'b1};
                end else begin
                    r_res  <= '0;
                end
            end else begin
                r_res <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_entry_id - ID_W'(1);
            r_grp   <= '0;
            r_gbase <= '0;
        end else if (r_busy) begin
            if (r_rem < w_epg) begin
                r_pos <= r_gbase + PW'(r_rem);
            end else begin
                r_rem   <= r_rem - w_epg;
                r_grp   <= r_grp + GW'(1);
                r_gbase <= r_gbase + PW'(MAX_PER_GROUP);
            end
        end
    end

    assign o_res = r_res;
    assign o_pos = r_pos;

endmodule

/* hw/rtl/inode_bitmap_allocator.sv */
// First-fit inode bitmap allocator. Command interface: a request (i_kind,
// i_entry_id) is taken on a clock edge with start high and busy low, and
// exactly one result (o_granted_id, o_status) is shown for one cycle with
// o_done high. The receiver cannot stall, so every result must be captured in
// its o_done cycle. The bitmap lives in a single memory of 32-bit words with
// a registered read port; each group owns MAX_PER_GROUP bit positions.
// After reset the block sweeps the memory to zero, one word per cycle, over all
// ceil(GROUPS*MAX_PER_GROUP/32) words (32 at the defaults) with busy high;
// register writes are taken during the sweep.
// An allocate reads memory words one after another until a free entry turns up,
// each group adding one word when it does not start word-aligned; with
// entries_per_group zero it answers full without a scan. A free finds the
// group by subtracting entries_per_group once per cycle, then reads the word
// and clears the bit if it was set. One request is in flight at a time; busy
// drops in the o_done cycle, so the next request may be taken then.
// entries_per_group is written through the APB port at byte address 0 and
// must only be changed while busy is low.
module inode_bitmap_allocator import ibmp_pkg::*; #(
    parameter int GROUPS        = DEF_GROUPS,
    parameter int MAX_PER_GROUP = DEF_MAX_PER_GROUP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request transaction
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_entry_id,
    // result transaction
    output logic               o_done,
    output logic [ID_W-1:0]    o_granted_id,
    output logic [1:0]         o_status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    `include "inode_bitmap_allocator_defines.svh"

    localparam int MAP_BITS  = GROUPS * MAX_PER_GROUP;
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    // bit position, wide enough for one past the last group and for a word index
    localparam int PW0       = $clog2(MAP_BITS + 1);
    localparam int PW        = (PW0 > AW + 5) ? PW0 : AW + 5;
    localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IDW0      = $clog2(GROUPS * 512);
    localparam int IDW       = (IDW0 > ID_W) ? IDW0 : ID_W;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [PW-1:0]      r_pos, n_pos;        // bit position of current scan point
    logic [CFG_W-1:0]   r_loc, n_loc;        // local index of that position
    logic [GW-1:0]      r_grp, n_grp;
    logic [PW-1:0]      r_gbase, n_gbase;    // first bit position of the group
    logic [IDW-1:0]     r_gid, n_gid;        // group * entries_per_group
    logic               r_done, n_done;
    logic [ID_W-1:0]    r_gid_out, n_gid_out;
    t_status            r_status, n_status;

    logic [CFG_W-1:0]   w_epg;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [WORD_W-1:0]  w_wdata, w_rdata;
    t_div_res           w_div_res;
    logic [PW-1:0]      w_div_pos;
    logic               w_div_start;

    // scan of one word
    logic [4:0]         w_off;
    logic [CFG_W-1:0]   w_rem;
    logic [WORD_W-1:0]  w_mask, w_free;
    logic [4:0]         w_fb;
    logic               w_found;
    logic [5:0]         w_step;
    logic [IDW-1:0]     w_grant;

    ibmp_cfg #(
        .MAX_PER_GROUP(MAX_PER_GROUP)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_epg   (w_epg)
    );

    ibmp_mem #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ibmp_idiv #(
        .GROUPS        (GROUPS),
        .MAX_PER_GROUP (MAX_PER_GROUP),
        .PW            (PW),
        .GW            (GW)
    ) u_idiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_entry_id (i_entry_id),
        .i_epg      (w_epg),
        .o_res      (w_div_res),
        .o_pos      (w_div_pos)
    );

    // Eligible bits of the word under scan: from the scan point on, and only
    // while the local index stays below entries_per_group.
    assign w_off  = r_pos[4:0];
    assign w_rem  = w_epg - r_loc;
    assign w_step = 6'd32 - {1'b0, w_off};

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_mask[b] = (5'(b) >= w_off) && ({4'b0, 5'(b) - w_off} < w_rem);
        end
    end

    assign w_free = ~w_rdata & w_mask;

    // lowest free eligible bit
    always_comb begin
        w_fb    = '0;
        w_found = 1'b0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_fb    = 5'(b);
                w_found = 1'b1;
            end
        end
    end

    assign w_grant = r_gid + IDW'(r_loc) + IDW'(w_fb - w_off) + IDW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_loc     <= n_loc;
        r_grp     <= n_grp;
        r_gbase   <= n_gbase;
        r_gid     <= n_gid;
        r_gid_out <= n_gid_out;
        r_status  <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pos       = r_pos;
        n_loc       = r_loc;
        n_grp       = r_grp;
        n_gbase     = r_gbase;
        n_gid       = r_gid;
        n_done      = 1'b0;
        n_gid_out   = r_gid_out;
        n_status    = r_status;
        w_we        = 1'b0;
        w_waddr     = r_pos[AW+4:5];
        w_wdata     = w_rdata;
        w_raddr     = '0;
        w_div_start = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            S_IDLE: begin
                // word 0 is read every idle cycle, ready for an allocate
                if (start) begin
                    if (t_kind'(i_kind) == KIND_ALLOC) begin
                        if (w_epg == '0) begin
                            n_done    = 1'b1;
                            n_gid_out = '0;
                            n_status  = ST_FULL;
                        end else begin
                            n_pos   = '0;
                            n_loc   = '0;
                            n_grp   = '0;
                            n_gbase = '0;
                            n_gid   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_FDIV;
                    end
                end
            end

            S_SCAN: begin
                if (w_found) begin
                    w_we      = 1'b1;
                    w_wdata   = w_rdata | (WORD_W'(1) << w_fb);
                    n_done    = 1'b1;
                    n_gid_out = w_grant[ID_W-1:0];
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end else if ({3'b0, w_step} >= w_rem) begin
                    // group exhausted
                    if (r_grp == GW'(GROUPS - 1)) begin
                        n_done    = 1'b1;
                        n_gid_out = '0;
                        n_status  = ST_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        n_grp   = r_grp + GW'(1);
                        n_gbase = r_gbase + PW'(MAX_PER_GROUP);
                        n_pos   = r_gbase + PW'(MAX_PER_GROUP);
                        n_loc   = '0;
                        n_gid   = r_gid + IDW'(w_epg);
                    end
                end else begin
                    n_pos = r_pos + PW'(w_step);
                    n_loc = r_loc + CFG_W'(w_step);
                end
                w_raddr = n_pos[AW+4:5];
            end

            S_FDIV: begin
                w_raddr = w_div_pos[AW+4:5];
                if (w_div_res.done) begin
                    if (w_div_res.range_err) begin
                        n_done    = 1'b1;
                        n_gid_out = '0;
                        n_status  = ST_RANGE;
                        n_state   = S_IDLE;
                    end else begin
                        n_pos   = w_div_pos;
                        n_state = S_FCHK;
                    end
                end
            end

            S_FCHK: begin
                n_done    = 1'b1;
                n_gid_out = '0;
                n_state   = S_IDLE;
                if (w_rdata[r_pos[4:0]]) begin
                    w_we     = 1'b1;
                    w_wdata  = w_rdata & ~(WORD_W'(1) << r_pos[4:0]);
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOT_USED;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_granted_id = r_gid_out;
    assign o_status     = r_status;

    `IBMP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "result while busy")
    `IBMP_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, start && !busy, busy || r_done, "request dropped")
    `IBMP_ASSERT_NOW(a_zero_id, i_clk, i_rst_n, r_done && r_status != ST_OK, r_gid_out == '0, "id on failure")
    `IBMP_ASSERT_NOW(a_write_state, i_clk, i_rst_n, w_we, r_state == S_CLEAR || r_state == S_SCAN || r_state == S_FCHK, "stray write")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

import ibmp_pkg::*;

typedef struct packed {
    logic [ID_W-1:0] granted;
    t_status         status;
} t_alloc_result;

// Mirror of the allocator bitmap plus the queue of results still owed by the block.
class alloc_scoreboard;
    localparam int NGROUPS = DEF_GROUPS;
    localparam int SLOTS   = DEF_MAX_PER_GROUP;

    bit [NGROUPS*SLOTS-1:0] used_bits;
    logic [CFG_W-1:0]       epg_reg;
    t_alloc_result          owed[$];
    int unsigned            errors;
    int unsigned            reported;

    function new();
        used_bits = '0;
        epg_reg   = CFG_W'(EPG_RESET);
        errors    = 0;
        reported  = 0;
    endfunction

    function void set_epg(logic [PDATA_W-1:0] value);
        epg_reg = value[CFG_W-1:0];
    endfunction

    // register value clamped to the per-group bit budget
    function int unsigned eff_epg();
        int unsigned e;
        e = 32'(epg_reg);
        if (e > SLOTS) e = SLOTS;
        return e;
    endfunction

    function int unsigned pos_of(int unsigned id, int unsigned e);
        return ((id - 1) / e) * SLOTS + (id - 1) % e;
    endfunction

    function int unsigned outstanding();
        return owed.size();
    endfunction

    // a random id that is most likely in use under the current register value
    function logic [ID_W-1:0] pick_used_id();
        int unsigned e;
        int unsigned id;
        e  = eff_epg();
        id = 1;
        if (e == 0) return ID_W'($urandom_range(2047));
        repeat (16) begin
            id = $urandom_range(NGROUPS * e, 1);
            if (used_bits[pos_of(id, e)]) return ID_W'(id);
        end
        return ID_W'(id);
    endfunction

    // accepted request: update the mirror and queue the result it must produce
    function void note_request(t_kind kind, logic [ID_W-1:0] id);
        t_alloc_result r;
        int unsigned   e;
        int unsigned   p;
        bit            found;
        e         = eff_epg();
        found     = 1'b0;
        r.granted = '0;
        if (kind == KIND_ALLOC) begin
            r.status = ST_FULL;
            for (int g = 0; g < NGROUPS && !found; g++) begin
                for (int l = 0; l < e && !found; l++) begin
                    p = g * SLOTS + l;
                    if (!used_bits[p]) begin
                        used_bits[p] = 1'b1;
                        r.granted    = ID_W'(g * e + l + 1);
                        r.status     = ST_OK;
                        found        = 1'b1;
                    end
                end
            end
        end else begin
            if (e == 0 || id == 0 || id > NGROUPS * e) begin
                r.status = ST_RANGE;
            end else begin
                p = pos_of(id, e);
                if (!used_bits[p]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    used_bits[p] = 1'b0;
                    r.status     = ST_OK;
                end
            end
        end
        owed.push_back(r);
    endfunction

    function void check_result(logic [ID_W-1:0] granted, logic [1:0] status);
        t_alloc_result want;
        if (owed.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("unexpected result: granted=%0d status=%0d", granted, status);
            end
            return;
        end
        want = owed.pop_front();
        if (granted !== want.granted || status !== want.status) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("mismatch: granted exp %0d got %0d, status exp %0d got %0d",
                         want.granted, granted, want.status, status);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    // worst allocate reads every bitmap word; this comfortably covers a late result
    localparam int DRAIN       = 64;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    logic                i_kind     = 1'b0;
    logic [ID_W-1:0]     i_entry_id = '0;
    logic                o_done;
    logic [ID_W-1:0]     o_granted_id;
    logic [1:0]          o_status;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    alloc_scoreboard     sb;
    int unsigned         cycle_count = 0;

    inode_bitmap_allocator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_entry_id   (i_entry_id),
        .o_done       (o_done),
        .o_granted_id (o_granted_id),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result monitor. The receiver cannot stall, so every o_done cycle is a
    // completed transaction; pre-edge values are sampled at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_granted_id, o_status);
    end

    // Issue one request transaction. Called at a rising edge; returns at the
    // edge where it was taken, leaving start high so a following request
    // can go out back to back without a bubble.
    task automatic send_request(input t_kind kind, input logic [ID_W-1:0] id);
        start      <= 1'b1;
        i_kind     <= kind;
        i_entry_id <= id;
        do @(posedge i_clk); while (busy);
        sb.note_request(kind, id);
    endtask

    // Random sender idling; the fields carry junk while start is low, which
    // the block must ignore.
    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start      <= 1'b0;
            i_kind     <= 1'($urandom_range(1));
            i_entry_id <= ID_W'($urandom_range(2047));
            @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every owed result is in and the block is idle.
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.outstanding() != 0 || busy) @(posedge i_clk);
    endtask

    // Two-phase APB write of entries_per_group; only ever called when idle.
    task automatic write_epg(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_EPG, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_epg(value);
    endtask

    // Directed checks: id extremes, both request kinds, empty geometry,
    // single-entry groups running full, and the saturating register.
    task automatic run_directed();
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, 11'h7FF);      // entry_id ignored on allocate
        send_request(KIND_FREE,  11'd2);
        send_request(KIND_FREE,  11'd2);        // already free
        send_request(KIND_FREE,  11'd0);        // id zero
        send_request(KIND_FREE,  11'd1024);     // highest valid id, never used
        send_request(KIND_FREE,  11'd1025);     // just past the last entry
        send_request(KIND_FREE,  11'h7FF);
        send_request(KIND_ALLOC, 11'h555);
        wait_idle();
        write_epg(32'd0);                       // no entries at all
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE,  11'd1);
        wait_idle();
        write_epg(32'd1);                       // one entry per group; old bits stay put
        repeat (4) send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE,  11'd4);
        send_request(KIND_FREE,  11'd5);
        send_request(KIND_FREE,  11'd3);
        send_request(KIND_ALLOC, 11'h2AA);
        wait_idle();
        write_epg(32'h1FF);                     // clamps to the per-group budget
        send_request(KIND_ALLOC, '0);
        wait_idle();
    endtask

    // One random phase under a fixed register value and idling mix.
    task automatic run_phase(input logic [PDATA_W-1:0] epg, input int n,
                             input int idle_pct, input int alloc_pct);
        int unsigned e;
        int          pick;
        wait_idle();
        write_epg(epg);
        e = sb.eff_epg();
        repeat (n) begin
            sender_gap(idle_pct);
            if ($urandom_range(99) < alloc_pct) begin
                send_request(KIND_ALLOC, ID_W'($urandom_range(2047)));
            end else begin
                pick = $urandom_range(9);
                if (pick < 6)
                    send_request(KIND_FREE, sb.pick_used_id());
                else if (pick < 8 && e != 0)
                    send_request(KIND_FREE, ID_W'($urandom_range(4 * e, 1)));
                else
                    send_request(KIND_FREE, ID_W'($urandom_range(2047)));
            end
        end
        wait_idle();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // the clearing sweep holds busy high; wait_idle rides it out
        wait_idle();

        run_directed();

        run_phase(32'd256, 250, 0,  75);
        run_phase(32'd1,   150, 75, 55);
        run_phase(32'd3,   200, 10, 60);
        run_phase(32'd0,    30, 0,  50);
        run_phase(32'd511, 200, 75, 70);
        run_phase(32'd7,   200, 0,  55);
        run_phase(32'd257 | ($urandom << CFG_W), 150, 10, 50);  // junk in upper bits
        run_phase(32'd32,  200, 75, 60);
        run_phase(32'd255, 200, 0,  65);
        run_phase(PDATA_W'($urandom_range(256, 1)), 250, 10, 55);

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
